[hdl/lbes_pkg.sv]
// ----------------------------------------------------------------------------
// LED brightness effect sequencer package
// Shared types, register indexes, effect codes and pause-length functions.
// ----------------------------------------------------------------------------
package lbes_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_STYLE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANDOM_COLOR = 3'd4;

  localparam logic [1:0] STYLE_STEADY    = 2'd0;
  localparam logic [1:0] STYLE_BREATHING = 2'd1;
  localparam logic [1:0] STYLE_FLASH     = 2'd2;
  localparam logic [1:0] STYLE_DOUBLE    = 2'd3;

  localparam logic [3:0] SPEED_RESET     = 4'd5;
  localparam logic [6:0] RANGE_MAX_RESET = 7'd100;

  localparam logic [6:0] STEADY_LAST = 7'd91;
  localparam logic [2:0] COLOR_LAST  = 3'd6;
  localparam logic [7:0] SHORT_GAP   = 8'd10;

  typedef struct packed {
    logic [1:0] style;
    logic [3:0] speed;
    logic [6:0] range_min;
    logic [6:0] range_max;
    logic       random_color;
  } lbes_cfg_t;

  // Idle length after a breathing cycle bottoms out.
  function automatic logic [5:0] breath_pause(input logic [3:0] spd);
    if (spd < 4'd10) begin
      return 6'((4'd10 - spd) * 5);
    end
    return 6'd0;
  endfunction

  // Pause after a flash returns to the minimum.
  function automatic logic [7:0] flash_pause(input logic [3:0] spd);
    if (spd <= 4'd11) begin
      return 8'((5'd12 - {1'b0, spd}) * 20 - 10);
    end
    return 8'd0;
  endfunction

  // Pause after the second pulse of a double flash.
  function automatic logic [7:0] double_pause(input logic [3:0] spd);
    if (spd <= 4'd10) begin
      return 8'((5'd11 - {1'b0, spd}) * 20);
    end
    return 8'd0;
  endfunction

endpackage

[hdl/lbes_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// Holds style, speed, range and color settings written over the cfg channel.
// ----------------------------------------------------------------------------
module lbes_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [lbes_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [lbes_pkg::CFG_DATA_W-1:0]  wr_data,
  output lbes_pkg::lbes_cfg_t              cfg
);

  lbes_pkg::lbes_cfg_t cfg_r;
  lbes_pkg::lbes_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        lbes_pkg::REG_STYLE:        cfg_nxt.style        = wr_data[1:0];
        lbes_pkg::REG_SPEED:        cfg_nxt.speed        = wr_data[3:0];
        lbes_pkg::REG_RANGE_MIN:    cfg_nxt.range_min    = wr_data[6:0];
        lbes_pkg::REG_RANGE_MAX:    cfg_nxt.range_max    = wr_data[6:0];
        lbes_pkg::REG_RANDOM_COLOR: cfg_nxt.random_color = wr_data[0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.style        <= lbes_pkg::STYLE_STEADY;
      cfg_r.speed        <= lbes_pkg::SPEED_RESET;
      cfg_r.range_min    <= 7'd0;
      cfg_r.range_max    <= lbes_pkg::RANGE_MAX_RESET;
      cfg_r.random_color <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/lbes_effect_core.sv]
// ----------------------------------------------------------------------------
// Effect state and tick update
// Holds the animation state and computes one tick's level and color.
// ----------------------------------------------------------------------------
module lbes_effect_core (
  input  logic                clk,
  input  logic                rst_n,
  input  lbes_pkg::lbes_cfg_t cfg,
  input  logic                step,
  output logic [6:0]          level,
  output logic [2:0]          color_index
);

  logic [6:0]        light_r,   light_nxt;
  logic signed [8:0] ramp_r,    ramp_nxt;
  logic              up_r,      up_nxt;
  logic [5:0]        bwait_r,   bwait_nxt;
  logic [7:0]        fwait_r,   fwait_nxt;
  logic [7:0]        dwait_r,   dwait_nxt;
  logic [1:0]        pulse_r,   pulse_nxt;
  logic [6:0]        steady_r,  steady_nxt;
  logic [2:0]        color_r,   color_nxt;
  logic [6:0]        kmin_r,    kmin_nxt;
  logic [6:0]        kmax_r,    kmax_nxt;

  logic              adv;
  logic              chg;
  logic [6:0]        light0;
  logic signed [8:0] ramp0;
  logic signed [8:0] ramp1;
  logic signed [8:0] smin;
  logic signed [8:0] smax;
  logic signed [8:0] clip;
  logic [6:0]        light1;
  logic [1:0]        pulse1;

  always_comb begin
    light_nxt  = light_r;
    ramp_nxt   = ramp_r;
    up_nxt     = up_r;
    bwait_nxt  = bwait_r;
    fwait_nxt  = fwait_r;
    dwait_nxt  = dwait_r;
    pulse_nxt  = pulse_r;
    steady_nxt = steady_r;
    kmin_nxt   = kmin_r;
    kmax_nxt   = kmax_r;
    adv        = 1'b0;
    level      = cfg.range_max;
    smin       = $signed({2'b00, cfg.range_min});
    smax       = $signed({2'b00, cfg.range_max});
    chg        = (cfg.range_min != kmin_r) || (cfg.range_max != kmax_r);
    light0     = chg ? cfg.range_min : light_r;
    ramp0      = chg ? smin : ramp_r;
    ramp1      = ramp0;
    clip       = ramp0;
    light1     = light0;
    pulse1     = pulse_r;

    if (cfg.style == lbes_pkg::STYLE_STEADY) begin
      if (steady_r >= lbes_pkg::STEADY_LAST) begin
        adv        = 1'b1;
        steady_nxt = 7'd0;
      end else begin
        steady_nxt = steady_r + 7'd1;
      end
    end else begin
      kmin_nxt  = cfg.range_min;
      kmax_nxt  = cfg.range_max;
      light_nxt = light0;
      ramp_nxt  = ramp0;
      level     = light0;
      case (cfg.style)
        lbes_pkg::STYLE_BREATHING: begin
          if (bwait_r != 6'd0) begin
            bwait_nxt = bwait_r - 6'd1;
          end else begin
            adv = (light0 == cfg.range_min);
            if (ramp0 <= smin || ramp0 >= smax) begin
              up_nxt = !up_r;
            end
            ramp1 = up_nxt ? ramp0 + 9'sd1 : ramp0 - 9'sd1;
            clip  = (ramp1 > smax) ? smax : ramp1;
            clip  = (clip < smin) ? smin : clip;
            light_nxt = clip[6:0];
            ramp_nxt  = ramp1;
            if (ramp1 <= 9'sd0) begin
              bwait_nxt = lbes_pkg::breath_pause(cfg.speed);
              ramp_nxt  = smin;
            end
          end
        end
        lbes_pkg::STYLE_FLASH: begin
          if (fwait_r != 8'd0) begin
            fwait_nxt = fwait_r - 8'd1;
          end else begin
            light1    = (light0 == cfg.range_min) ? cfg.range_max : cfg.range_min;
            light_nxt = light1;
            fwait_nxt = (light1 == cfg.range_min) ? lbes_pkg::flash_pause(cfg.speed)
                                                  : lbes_pkg::SHORT_GAP;
          end
        end
        default: begin
          if (dwait_r != 8'd0) begin
            dwait_nxt = dwait_r - 8'd1;
          end else begin
            adv       = (pulse_r == 2'd0) && (light0 == cfg.range_min);
            light1    = (light0 == cfg.range_min) ? cfg.range_max : cfg.range_min;
            light_nxt = light1;
            dwait_nxt = lbes_pkg::SHORT_GAP;
            pulse1    = pulse_r;
            if (pulse_r == 2'd2) begin
              dwait_nxt = lbes_pkg::double_pause(cfg.speed);
              pulse1    = 2'd0;
            end
            pulse_nxt = (light1 == cfg.range_max) ? pulse1 + 2'd1 : pulse1;
          end
        end
      endcase
    end

    color_nxt = color_r;
    if (adv && cfg.random_color) begin
      color_nxt = (color_r >= lbes_pkg::COLOR_LAST) ? 3'd0 : color_r + 3'd1;
    end
    color_index = color_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r  <= 7'd0;
      ramp_r   <= 9'sd0;
      up_r     <= 1'b0;
      bwait_r  <= 6'd0;
      fwait_r  <= 8'd0;
      dwait_r  <= 8'd0;
      pulse_r  <= 2'd0;
      steady_r <= 7'd0;
      color_r  <= 3'd0;
      kmin_r   <= 7'd0;
      kmax_r   <= 7'd0;
    end else if (step) begin
      light_r  <= light_nxt;
      ramp_r   <= ramp_nxt;
      up_r     <= up_nxt;
      bwait_r  <= bwait_nxt;
      fwait_r  <= fwait_nxt;
      dwait_r  <= dwait_nxt;
      pulse_r  <= pulse_nxt;
      steady_r <= steady_nxt;
      color_r  <= color_nxt;
      kmin_r   <= kmin_nxt;
      kmax_r   <= kmax_nxt;
    end
  end

endmodule

[hdl/led_brightness_effect_sequencer.sv]
// ----------------------------------------------------------------------------
// LED brightness effect sequencer
// Steady, breathing, flash and double-flash brightness effects with an
// optional cycling color slot, one result item per tick item.
// ----------------------------------------------------------------------------
// Each tick item is taken into an input register, the effect state is
// updated in one pass, and the result lands in an output register, so the
// block accepts one item per clock cycle while the output is not stalled.
// A tick moves on from the input register when the output register is empty
// or its result is being taken; a stalled output holds one result while a
// second tick waits in the input register. Configuration writes are
// registered and must be made while no tick is in flight.
module led_brightness_effect_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [2:0] target
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // [6:0] level, [9:7] target_out,
                                                      // [12:10] color_index
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lbes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbes_pkg::CFG_DATA_W-1:0] cfg_data
);

  lbes_pkg::lbes_cfg_t cfg;

  logic       in_vld_r,  in_vld_nxt;
  logic [2:0] in_tgt_r;
  logic       out_vld_r, out_vld_nxt;
  logic [6:0] out_level_r;
  logic [2:0] out_tgt_r;
  logic [2:0] out_color_r;
  logic       advance;
  logic       step;
  logic [6:0] level;
  logic [2:0] color_index;

  assign cfg_ready = 1'b1;

  lbes_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  lbes_effect_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .step        (step),
    .level       (level),
    .color_index (color_index)
  );

  assign advance   = !out_vld_r || out_tready;
  assign step      = in_vld_r && advance;
  assign in_tready = !in_vld_r || advance;

  always_comb begin
    in_vld_nxt  = in_tready ? in_tvalid : in_vld_r;
    out_vld_nxt = advance ? in_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_tgt_r <= in_tdata[2:0];
    end
    if (step) begin
      out_level_r <= level;
      out_tgt_r   <= in_tgt_r;
      out_color_r <= color_index;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_color_r, out_tgt_r, out_level_r};

endmodule

[hdl/lbes_checker.sv]
// ----------------------------------------------------------------------------
// LED brightness effect sequencer checker
// Port-level assertions on the sequencer, attached by a bind statement.
// ----------------------------------------------------------------------------
module lbes_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] out_tdata,
  input logic        out_tvalid,
  input logic        out_tready
);

  logic in_fire;
  assign in_fire = in_tvalid & in_tready;

  // The output register empties during reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result item valid right after reset");

  // A result carries a color slot in range and zero padding.
  a_color_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[12:10] <= lbes_pkg::COLOR_LAST) && (out_tdata[15:13] == 3'd0))
    else $error("result item has a bad color slot or padding");

  // With the output empty, the input side must be open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output is empty");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result item changed");

  // An accepted tick item is followed by a valid output.
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##2 out_tvalid)
    else $error("accepted tick item produced no result item");

endmodule

bind led_brightness_effect_sequencer lbes_checker u_lbes_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
